// ===== sv/csvp_pkg.sv =====
// Shared types and constants for the cube-to-sphere vertex projection block.
// No dependencies.
package csvp_pkg;

  localparam int LEVEL_W = 3;
  localparam int RAD_W   = 16;
  localparam int COORD_W = RAD_W + 1;
  localparam int IDX_W   = 8;
  localparam int FACE_W  = 3;
  localparam int DEF_MAX_LEVEL = 7;

  localparam logic [LEVEL_W-1:0] LEVEL_RST  = 3'd1;
  localparam logic [RAD_W-1:0]   RADIUS_RST = 16'd256;

  // configuration register indexes
  localparam logic CFG_LEVEL  = 1'b0;
  localparam logic CFG_RADIUS = 1'b1;

  // face order: +z, -z, -y, +y, +x, -x
  localparam logic [FACE_W-1:0] FACE_ZP = 3'd0;
  localparam logic [FACE_W-1:0] FACE_ZN = 3'd1;
  localparam logic [FACE_W-1:0] FACE_YN = 3'd2;
  localparam logic [FACE_W-1:0] FACE_YP = 3'd3;
  localparam logic [FACE_W-1:0] FACE_XP = 3'd4;
  localparam logic [FACE_W-1:0] FACE_XN = 3'd5;

  // per-stage control traveling alongside the payload
  typedef struct packed {
    logic vld;
    logic neg_a;
    logic neg_b;
  } ctl_t;

endpackage

// ===== sv/csvp_prep.sv =====
// Front stages: clamp the grid point, form |a|,|b|,n, the squared norm D and
// the square targets t = 4*k^2*R^2 for the three lanes. Uses csvp_pkg.
module csvp_prep #(
  parameter int MAX_LEVEL = csvp_pkg::DEF_MAX_LEVEL
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic                                  in_vld,
  input  logic [csvp_pkg::IDX_W-1:0]            col,
  input  logic [csvp_pkg::IDX_W-1:0]            row,
  input  logic [csvp_pkg::LEVEL_W-1:0]          level,
  input  logic [csvp_pkg::RAD_W-1:0]            radius,
  output csvp_pkg::ctl_t                        ctl_o,
  output logic [2*MAX_LEVEL+1:0]                d_o,
  output logic [2:0][2*MAX_LEVEL+2*csvp_pkg::RAD_W+1:0] t_o
);
  localparam int N_W   = MAX_LEVEL + 1;
  localparam int LVW   = $clog2(MAX_LEVEL + 1);
  localparam int D_W   = 2 * MAX_LEVEL + 2;
  localparam int KSQ_W = 2 * N_W;
  localparam int RR_W  = 2 * csvp_pkg::RAD_W;
  localparam int T_W   = 2 * MAX_LEVEL + 2 * csvp_pkg::RAD_W + 2;

  logic [LVW-1:0] lvl;
  logic [N_W-1:0] n, c, r, ka, kb;
  logic [N_W:0]   c2, r2, nn;
  logic           neg_a, neg_b;

  always_comb begin
    if (level == '0) lvl = LVW'(1);
    else if (int'(level) > MAX_LEVEL) lvl = LVW'(MAX_LEVEL);
    else lvl = LVW'(level);
    n  = N_W'(1) << lvl;
    c  = (int'(col) > int'(n)) ? n : N_W'(col);
    r  = (int'(row) > int'(n)) ? n : N_W'(row);
    c2 = {c, 1'b0};
    r2 = {r, 1'b0};
    nn = {1'b0, n};
    neg_a = c2 < nn;
    neg_b = r2 > nn;
    ka = neg_a ? N_W'(nn - c2) : N_W'(c2 - nn);
    kb = neg_b ? N_W'(r2 - nn) : N_W'(nn - r2);
  end

  csvp_pkg::ctl_t               ctl1_r;
  logic [2:0][KSQ_W-1:0]        ksq_r;
  logic [D_W-1:0]               d1_r;
  logic [RR_W-1:0]              rr_r;
  logic [KSQ_W+RR_W+1:0]        prod [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl_o  <= '0;
    end else if (en) begin
      ctl1_r <= '{vld: in_vld, neg_a: neg_a, neg_b: neg_b};
      ctl_o  <= ctl1_r;
    end
  end

  // full-width product, the concatenation alone would size it to RR_W
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod[i] = {(KSQ_W+RR_W)'(ksq_r[i]) * (KSQ_W+RR_W)'(rr_r), 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ksq_r[0] <= ka * ka;
      ksq_r[1] <= kb * kb;
      ksq_r[2] <= n * n;
      d1_r     <= D_W'(ka * ka) + D_W'(kb * kb) + D_W'(n * n);
      rr_r     <= radius * radius;
      d_o      <= d1_r;
      for (int i = 0; i < 3; i++) t_o[i] <= prod[i][T_W-1:0];
    end
  end
endmodule

// ===== sv/csvp_cell.sv =====
// One cell of the root chain: decides bit J of s = floor(sqrt(t/D)) for three
// lanes, keeping e = t - s^2*D and sd = s*D. Uses csvp_pkg.
module csvp_cell #(
  parameter int MAX_LEVEL = csvp_pkg::DEF_MAX_LEVEL,
  parameter int J = 0
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          en,
  input  csvp_pkg::ctl_t                                ctl_i,
  input  logic [2*MAX_LEVEL+1:0]                        d_i,
  input  logic [2:0][2*MAX_LEVEL+2*csvp_pkg::RAD_W+1:0] e_i,
  input  logic [2:0][2*MAX_LEVEL+csvp_pkg::COORD_W+1:0] sd_i,
  input  logic [2:0][csvp_pkg::COORD_W-1:0]             s_i,
  output csvp_pkg::ctl_t                                ctl_o,
  output logic [2*MAX_LEVEL+1:0]                        d_o,
  output logic [2:0][2*MAX_LEVEL+2*csvp_pkg::RAD_W+1:0] e_o,
  output logic [2:0][2*MAX_LEVEL+csvp_pkg::COORD_W+1:0] sd_o,
  output logic [2:0][csvp_pkg::COORD_W-1:0]             s_o
);
  localparam int S_W  = csvp_pkg::COORD_W;
  localparam int D_W  = 2 * MAX_LEVEL + 2;
  localparam int T_W  = 2 * MAX_LEVEL + 2 * csvp_pkg::RAD_W + 2;
  localparam int SD_W = S_W + D_W;
  localparam int C_W  = 2 * S_W + D_W + 1;

  logic [C_W-1:0] cand [3];
  logic           take [3];

  // trying s + 2^J costs (2^(J+1)*s + 4^J) * D
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cand[i] = ({{(C_W-SD_W){1'b0}}, sd_i[i]} << (J + 1))
              + ({{(C_W-D_W){1'b0}}, d_i} << (2 * J));
      take[i] = cand[i] <= {{(C_W-T_W){1'b0}}, e_i[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ctl_o <= '0;
    else if (en) ctl_o <= ctl_i;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_o <= d_i;
      for (int i = 0; i < 3; i++) begin
        if (take[i]) begin
          e_o[i]  <= e_i[i] - cand[i][T_W-1:0];
          sd_o[i] <= sd_i[i] + ({{S_W{1'b0}}, d_i} << J);
          s_o[i]  <= s_i[i] | (S_W'(1) << J);
        end else begin
          e_o[i]  <= e_i[i];
          sd_o[i] <= sd_i[i];
          s_o[i]  <= s_i[i];
        end
      end
    end
  end
endmodule

// ===== sv/cube_sphere_vertex_projection.sv =====
// Top level of the cube-to-sphere vertex projection block.
// Depends on csvp_pkg, csvp_prep and csvp_cell.
//
// Each input transaction (col,row) yields six output transactions, faces 0..5
// in order, one per cycle while out_tready is high, with tlast on face 5. The
// six results share the single output channel. A grid point passes two setup
// stages, then a chain of 17 cells that each settle one bit of the root for
// the three lanes (|a|, |b|, n). Up to 19 grid points sit in the chain while
// results drain. Coordinates are round(k*R/sqrt(D)), ties away from zero.
module cube_sphere_vertex_projection #(
  parameter int MAX_LEVEL = csvp_pkg::DEF_MAX_LEVEL
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic                              cfg_addr,
  input  logic [csvp_pkg::RAD_W-1:0]        cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [15:0]                       in_tdata,   // col[7:0], row[15:8]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [55:0]                       out_tdata,  // x[16:0], y[33:17], z[50:34], 0
  output logic [csvp_pkg::FACE_W-1:0]       out_tuser,  // face[2:0]
  output logic                              out_tlast
);
  localparam int S_W  = csvp_pkg::COORD_W;
  localparam int D_W  = 2 * MAX_LEVEL + 2;
  localparam int T_W  = 2 * MAX_LEVEL + 2 * csvp_pkg::RAD_W + 2;
  localparam int SD_W = S_W + D_W;

  logic [csvp_pkg::LEVEL_W-1:0] level_r;
  logic [csvp_pkg::RAD_W-1:0]   radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r  <= csvp_pkg::LEVEL_RST;
      radius_r <= csvp_pkg::RADIUS_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        csvp_pkg::CFG_LEVEL:  level_r  <= cfg_wdata[csvp_pkg::LEVEL_W-1:0];
        csvp_pkg::CFG_RADIUS: radius_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  csvp_pkg::ctl_t              ch_ctl [S_W+1];
  logic [D_W-1:0]              ch_d   [S_W+1];
  logic [2:0][T_W-1:0]         ch_e   [S_W+1];
  logic [2:0][SD_W-1:0]        ch_sd  [S_W+1];
  logic [2:0][S_W-1:0]         ch_s   [S_W+1];

  logic adv, free, load, out_take, last_face;

  csvp_prep #(.MAX_LEVEL(MAX_LEVEL)) u_prep (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .in_vld (in_tvalid),
    .col    (in_tdata[7:0]),
    .row    (in_tdata[15:8]),
    .level  (level_r),
    .radius (radius_r),
    .ctl_o  (ch_ctl[0]),
    .d_o    (ch_d[0]),
    .t_o    (ch_e[0])
  );

  assign ch_sd[0] = '0;
  assign ch_s[0]  = '0;

  for (genvar k = 0; k < S_W; k++) begin : g_cell
    csvp_cell #(.MAX_LEVEL(MAX_LEVEL), .J(S_W - 1 - k)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .ctl_i (ch_ctl[k]),
      .d_i   (ch_d[k]),
      .e_i   (ch_e[k]),
      .sd_i  (ch_sd[k]),
      .s_i   (ch_s[k]),
      .ctl_o (ch_ctl[k+1]),
      .d_o   (ch_d[k+1]),
      .e_o   (ch_e[k+1]),
      .sd_o  (ch_sd[k+1]),
      .s_o   (ch_s[k+1])
    );
  end

  // face sequencer
  logic                          busy_r;
  logic [csvp_pkg::FACE_W-1:0]   face_r;
  logic signed [S_W-1:0]         pu_r, pv_r, ph_r;
  logic signed [S_W-1:0]         mh, pu_nxt, pv_nxt, ph_nxt;
  logic [S_W:0]                  rnd [3];
  logic signed [S_W-1:0]         cx, cy, cz;

  assign out_take  = out_tvalid && out_tready;
  assign last_face = face_r == csvp_pkg::FACE_XN;
  assign free      = !busy_r || (out_take && last_face);
  assign load      = ch_ctl[S_W].vld && free;
  assign adv       = !ch_ctl[S_W].vld || free;
  assign in_tready = adv;

  always_comb begin
    for (int i = 0; i < 3; i++) rnd[i] = {1'b0, ch_s[S_W][i]} + (S_W+1)'(1);
    pu_nxt = ch_ctl[S_W].neg_a ? -$signed(rnd[0][S_W:1]) : $signed(rnd[0][S_W:1]);
    pv_nxt = ch_ctl[S_W].neg_b ? -$signed(rnd[1][S_W:1]) : $signed(rnd[1][S_W:1]);
    ph_nxt = $signed(rnd[2][S_W:1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      face_r <= csvp_pkg::FACE_ZP;
    end else if (load) begin
      busy_r <= 1'b1;
      face_r <= csvp_pkg::FACE_ZP;
    end else if (out_take) begin
      if (last_face) busy_r <= 1'b0;
      else face_r <= face_r + csvp_pkg::FACE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pu_r <= pu_nxt;
      pv_r <= pv_nxt;
      ph_r <= ph_nxt;
    end
  end

  assign mh = -ph_r;

  always_comb begin
    unique case (face_r)
      csvp_pkg::FACE_ZP: begin cx = pu_r; cy = pv_r; cz = ph_r; end
      csvp_pkg::FACE_ZN: begin cx = pu_r; cy = pv_r; cz = mh;   end
      csvp_pkg::FACE_YN: begin cx = pu_r; cy = mh;   cz = pv_r; end
      csvp_pkg::FACE_YP: begin cx = pu_r; cy = ph_r; cz = pv_r; end
      csvp_pkg::FACE_XP: begin cx = ph_r; cy = pu_r; cz = pv_r; end
      csvp_pkg::FACE_XN: begin cx = mh;   cy = pu_r; cz = pv_r; end
      default:           begin cx = '0;   cy = '0;   cz = '0;   end
    endcase
  end

  assign out_tvalid = busy_r;
  assign out_tdata  = {5'b0, cz, cy, cx};
  assign out_tuser  = face_r;
  assign out_tlast  = last_face;
endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for cube_sphere_vertex_projection.
// Predicts the six face vertices per grid point and compares each output
// transaction in order. Depends on csvp_pkg and the RTL only.
`timescale 1ns / 100ps

module tb_top;
  import csvp_pkg::*;

  typedef struct packed {
    logic [FACE_W-1:0]  face;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic               last;
  } vertex_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic              cfg_addr = 1'b0;
  logic [RAD_W-1:0]  cfg_wdata = '0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [15:0]       in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [55:0]       out_tdata;
  logic [FACE_W-1:0] out_tuser;
  logic              out_tlast;

  cube_sphere_vertex_projection dut (.*);

  // predictor copy of the registers
  logic [LEVEL_W-1:0] lvl_q = LEVEL_RST;
  logic [RAD_W-1:0]   rad_q = RADIUS_RST;

  vertex_t expected_vertices[$];
  int      n_errors = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  longint  cycle_cnt = 0;

  localparam longint CYCLE_LIMIT = 400000;

  initial forever #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r, bit_v;
    r = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > v) bit_v >>= 2;
    while (bit_v != 0) begin
      if (v >= r + bit_v) begin
        v -= r + bit_v;
        r = (r >> 1) + bit_v;
      end else begin
        r >>= 1;
      end
      bit_v >>= 2;
    end
    return r;
  endfunction

  // round(k*R/sqrt(d)) ties away from zero, done exactly in integers
  function automatic logic [COORD_W-1:0] scale_coord(longint k, longint unsigned d);
    longint unsigned ak, t, q;
    ak = (k < 0) ? longint'(-k) : longint'(k);
    t = 4 * ak * ak * rad_q * rad_q;
    q = (isqrt(t / d) + 1) / 2;
    if (k < 0) q = -q;
    return q[COORD_W-1:0];
  endfunction

  task automatic predict_vertices(input logic [7:0] col, input logic [7:0] row);
    int     l;
    longint n, c, r, a, b;
    longint unsigned d;
    logic [COORD_W-1:0] pu, pv, ph, mh;
    logic [COORD_W-1:0] tx[6], ty[6], tz[6];
    vertex_t vx;
    l = lvl_q;
    if (l < 1) l = 1;
    if (l > DEF_MAX_LEVEL) l = DEF_MAX_LEVEL;
    n = 64'sd1 << l;
    c = (col > n) ? n : col;
    r = (row > n) ? n : row;
    a = 2 * c - n;
    b = n - 2 * r;
    d = a * a + b * b + n * n;
    pu = scale_coord(a, d);
    pv = scale_coord(b, d);
    ph = scale_coord(n, d);
    mh = scale_coord(-n, d);
    tx = '{pu, pu, pu, pu, ph, mh};
    ty = '{pv, pv, mh, ph, pu, pu};
    tz = '{ph, mh, pv, pv, pv, pv};
    for (int f = 0; f < 6; f++) begin
      vx.face = f[FACE_W-1:0];
      vx.x = tx[f];
      vx.y = ty[f];
      vx.z = tz[f];
      vx.last = (f[FACE_W-1:0] == FACE_XN);
      expected_vertices.push_back(vx);
    end
  endtask

  // result checker and random receiver stall
  always @(posedge clk) begin
    vertex_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.face = out_tuser;
      got.x = out_tdata[16:0];
      got.y = out_tdata[33:17];
      got.z = out_tdata[50:34];
      got.last = out_tlast;
      if (expected_vertices.size() == 0) begin
        $display("%0t: unexpected transaction face=%0d x=%h y=%h z=%h",
                 $time, got.face, got.x, got.y, got.z);
        n_errors++;
      end else begin
        want = expected_vertices.pop_front();
        if (got.face !== want.face) begin
          $display("%0t: face exp %0d got %0d", $time, want.face, got.face); n_errors++;
        end
        if (got.x !== want.x) begin
          $display("%0t: x exp %h got %h", $time, want.x, got.x); n_errors++;
        end
        if (got.y !== want.y) begin
          $display("%0t: y exp %h got %h", $time, want.y, got.y); n_errors++;
        end
        if (got.z !== want.z) begin
          $display("%0t: z exp %h got %h", $time, want.z, got.z); n_errors++;
        end
        if (got.last !== want.last) begin
          $display("%0t: last exp %0d got %0d", $time, want.last, got.last); n_errors++;
        end
      end
    end
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // tvalid stays up after a transaction; idle cycles and drain() drop it
  task automatic send_point(input logic [7:0] col, input logic [7:0] row);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {row, col};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_vertices(col, row);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_vertices.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [RAD_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_LEVEL) lvl_q = val[LEVEL_W-1:0];
    else rad_q = val;
    @(posedge clk);
  endtask

  // corners, center, clamping, all-ones fields, at reset settings then extremes
  task automatic test_directed();
    send_point(0, 0);
    send_point(1, 1);
    send_point(2, 2);
    send_point(8'hFF, 8'hFF);
    send_point(8'hAA, 8'h55);
    send_point(8'h55, 8'hAA);
    drain();
    write_reg(CFG_LEVEL, 0);
    write_reg(CFG_RADIUS, 16'hFFFF);
    send_point(0, 2);
    send_point(1, 0);
    drain();
    write_reg(CFG_LEVEL, 7);
    send_point(0, 0);
    send_point(128, 128);
    send_point(64, 64);
    send_point(0, 128);
    send_point(127, 1);
    drain();
    write_reg(CFG_RADIUS, 0);
    send_point(5, 77);
    drain();
    write_reg(CFG_LEVEL, 3'h7);
    write_reg(CFG_RADIUS, 1);
    send_point(3, 100);
    drain();
  endtask

  task automatic test_random(input int count, input int idle, input int stall);
    int lv;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < count; i++) begin
      if (i % 30 == 0) begin
        drain();
        write_reg(CFG_LEVEL, RAD_W'($urandom_range(7)));
        case ($urandom_range(3))
          0: write_reg(CFG_RADIUS, 16'hFFFF);
          1: write_reg(CFG_RADIUS, 0);
          default: write_reg(CFG_RADIUS, RAD_W'($urandom_range(16'hFFFF)));
        endcase
      end
      lv = (lvl_q < 1) ? 1 : lvl_q;
      // mostly on-grid points, some beyond the grid
      if ($urandom_range(9) < 8)
        send_point(8'($urandom_range(1 << lv)), 8'($urandom_range(1 << lv)));
      else
        send_point(8'($urandom_range(255)), 8'($urandom_range(255)));
      if (i == count / 2) drain();  // sender holds until everything is back
    end
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(120, 0, 0);
    test_random(120, 56, 0);
    test_random(120, 0, 56);
    test_random(120, 36, 36);
    if (n_errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
